/* hw/rtl/hrrl_pkg.sv */
// Shared types and constants for the hash ring replica lookup block.
package hrrl_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int RING_DEPTH_DEF   = 1024;
    localparam int MAX_REPLICAS_DEF = 8;

    // Fixed field widths.
    localparam int POINT_W  = 32;
    localparam int SERVER_W = 6;
    localparam int POS_W    = 10;
    localparam int REP_W    = 4;

    // Register index of replica_count.
    localparam logic REG_REPLICA = 1'b0;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FEW   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PUT,
        S_LK_A,
        S_LK_B,
        S_EMIT
    } t_state;

    // What the cell chain does: hold, rotate or insert.
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_ROT,
        CM_INS
    } t_cmode;

    typedef struct packed {
        t_cmode                mode;
        logic [POINT_W-1:0]    pt;
        logic [SERVER_W-1:0]   srv;
    } t_chain_ctl;

endpackage

/* hw/rtl/hrrl_cell.sv */
// One ring entry cell: holds a point and a server and trades with its neighbors.
module hrrl_cell #(
    parameter int IDX = 0,
    parameter int CW  = 11,
    parameter int AW  = 10
) (
    input  logic                          i_clk,
    input  hrrl_pkg::t_chain_ctl          i_ctl,
    input  logic [CW-1:0]                 i_count,
    input  logic [AW-1:0]                 i_pos,
    input  logic [hrrl_pkg::POINT_W-1:0]  i_left_pt,
    input  logic [hrrl_pkg::SERVER_W-1:0] i_left_srv,
    input  logic [hrrl_pkg::POINT_W-1:0]  i_right_pt,
    input  logic [hrrl_pkg::SERVER_W-1:0] i_right_srv,
    input  logic [hrrl_pkg::POINT_W-1:0]  i_head_pt,
    input  logic [hrrl_pkg::SERVER_W-1:0] i_head_srv,
    output logic [hrrl_pkg::POINT_W-1:0]  o_pt,
    output logic [hrrl_pkg::SERVER_W-1:0] o_srv
);
    import hrrl_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);
    localparam logic [CW-1:0] NXT_C = CW'(IDX + 1);

    logic [POINT_W-1:0]  r_pt,  n_pt;
    logic [SERVER_W-1:0] r_srv, n_srv;
    logic [CW-1:0]       pos_ext;

    assign pos_ext = CW'(i_pos);

    // Rotation moves every valid entry one cell toward the head; insertion
    // opens a gap at the insert slot by shifting the tail one cell outward.
    always_comb begin
        n_pt  = r_pt;
        n_srv = r_srv;
        case (i_ctl.mode)
            CM_ROT: begin
                if (NXT_C < i_count) begin
                    n_pt  = i_right_pt;
                    n_srv = i_right_srv;
                end else if (NXT_C == i_count) begin
                    n_pt  = i_head_pt;
                    n_srv = i_head_srv;
                end
            end
            CM_INS: begin
                if (IDX_C == pos_ext) begin
                    n_pt  = i_ctl.pt;
                    n_srv = i_ctl.srv;
                end else if (IDX_C > pos_ext && IDX_C <= i_count) begin
                    n_pt  = i_left_pt;
                    n_srv = i_left_srv;
                end
            end
            default: begin
                n_pt  = r_pt;
                n_srv = r_srv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pt  <= n_pt;
        r_srv <= n_srv;
    end

    assign o_pt  = r_pt;
    assign o_srv = r_srv;

endmodule

/* hw/rtl/hrrl_chain.sv */
// Row of ring entry cells, with cell 0 as the read head.
module hrrl_chain #(
    parameter int RING_DEPTH = hrrl_pkg::RING_DEPTH_DEF,
    parameter int CW         = 11,
    parameter int AW         = 10
) (
    input  logic                          i_clk,
    input  hrrl_pkg::t_chain_ctl          i_ctl,
    input  logic [CW-1:0]                 i_count,
    input  logic [AW-1:0]                 i_pos,
    output logic [hrrl_pkg::POINT_W-1:0]  o_head_pt,
    output logic [hrrl_pkg::SERVER_W-1:0] o_head_srv
);
    import hrrl_pkg::*;

    logic [POINT_W-1:0]  w_pt  [RING_DEPTH];
    logic [SERVER_W-1:0] w_srv [RING_DEPTH];

    // Each cell sees its two neighbors and the head; the last cell wraps to cell 0.
    for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
        logic [POINT_W-1:0]  l_pt,  rt_pt;
        logic [SERVER_W-1:0] l_srv, rt_srv;

        if (i == 0) begin : g_first
            assign l_pt  = i_ctl.pt;
            assign l_srv = i_ctl.srv;
        end else begin : g_mid_l
            assign l_pt  = w_pt[i-1];
            assign l_srv = w_srv[i-1];
        end

        if (i == RING_DEPTH - 1) begin : g_last
            assign rt_pt  = w_pt[0];
            assign rt_srv = w_srv[0];
        end else begin : g_mid_r
            assign rt_pt  = w_pt[i+1];
            assign rt_srv = w_srv[i+1];
        end

        hrrl_cell #(
            .IDX (i),
            .CW  (CW),
            .AW  (AW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_count     (i_count),
            .i_pos       (i_pos),
            .i_left_pt   (l_pt),
            .i_left_srv  (l_srv),
            .i_right_pt  (rt_pt),
            .i_right_srv (rt_srv),
            .i_head_pt   (w_pt[0]),
            .i_head_srv  (w_srv[0]),
            .o_pt        (w_pt[i]),
            .o_srv       (w_srv[i])
        );
    end

    assign o_head_pt  = w_pt[0];
    assign o_head_srv = w_srv[0];

endmodule

/* hw/rtl/hash_ring_replica_lookup_core.sv */
// Top level of the hash ring replica lookup block: control, config and results.
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+---------------------------
//  request   | i_cmd, i_point, i_server_id                  | i_start high, o_busy low
//  result    | o_position, o_server, o_last, o_status       | o_valid strobe, one cycle
//  config    | i_psel, i_penable, i_pwrite, i_paddr, i_pwdata, o_prdata, o_pready | APB
//
//  The ring is a row of cells that rotates one entry per cycle past cell 0
//  during a scan pass. Clear, a full insert and an empty lookup answer from
//  idle; an insert makes one pass over the ring fill, a lookup two and then
//  lists replicas or flags too few. The chain always stops with the smallest
//  point in cell 0. Reset empties the ring and sets replica_count to 1; no
//  clearing pass. Results cannot be stalled; o_busy falls as the last shows.
module hash_ring_replica_lookup_core #(
    parameter int RING_DEPTH   = hrrl_pkg::RING_DEPTH_DEF,
    parameter int MAX_REPLICAS = hrrl_pkg::MAX_REPLICAS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_cmd,
    input  logic [hrrl_pkg::POINT_W-1:0]  i_point,
    input  logic [hrrl_pkg::SERVER_W-1:0] i_server_id,
    output logic                          o_valid,
    output logic [hrrl_pkg::POS_W-1:0]    o_position,
    output logic [hrrl_pkg::SERVER_W-1:0] o_server,
    output logic                          o_last,
    output logic [1:0]                    o_status,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [2:0]                    i_paddr,
    input  logic [31:0]                   i_pwdata,
    output logic [31:0]                   o_prdata,
    output logic                          o_pready
);
    import hrrl_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int GW = $clog2(MAX_REPLICAS + 1);
    localparam int IW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
    localparam logic [GW-1:0] MAXR_C  = GW'(MAX_REPLICAS);

    t_state r_state, n_state;

    logic [REP_W-1:0]    r_rep;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_k, n_k;
    logic [AW-1:0]       r_pos, n_pos;
    logic                r_found, n_found;
    logic [POINT_W-1:0]  r_q, n_q;
    logic [SERVER_W-1:0] r_sid, n_sid;
    logic [GW-1:0]       r_got, n_got;
    logic [GW-1:0]       r_want, n_want;
    logic [GW-1:0]       r_e, n_e;
    logic [SERVER_W-1:0] r_chosen [MAX_REPLICAS];
    logic [AW-1:0]       r_slot   [MAX_REPLICAS];

    logic                r_ovalid, n_ovalid;
    logic [POS_W-1:0]    r_opos,   n_opos;
    logic [SERVER_W-1:0] r_osrv,   n_osrv;
    logic                r_olast,  n_olast;
    t_status             r_ostat,  n_ostat;

    logic                accept;
    logic                wr_cfg;
    logic                pass_end;
    logic                seen;
    logic                take;
    logic                ge_q;
    logic [GW-1:0]       want_c;
    t_chain_ctl          ctl;
    logic [POINT_W-1:0]  head_pt;
    logic [SERVER_W-1:0] head_srv;

    assign accept   = i_start && !o_busy;
    assign pass_end = (r_k == r_count - CW'(1));
    assign ge_q     = (head_pt >= r_q);

    // Configuration register; the user must write it only while idle: the block does not enforce this.
    assign wr_cfg   = i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_REPLICA);
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_REPLICA) ? 32'(r_rep) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep <= REP_W'(1);
        end else if (wr_cfg) begin
            r_rep <= i_pwdata[REP_W-1:0];
        end
    end

    // Requested replica count, clamped to one through MAX_REPLICAS.
    always_comb begin
        if (r_rep == '0) begin
            want_c = GW'(1);
        end else if (32'(r_rep) > 32'(MAX_REPLICAS)) begin
            want_c = MAXR_C;
        end else begin
            want_c = GW'(r_rep);
        end
    end

    // The head server is a duplicate if any already chosen server matches.
    always_comb begin
        seen = 1'b0;
        for (int j = 0; j < MAX_REPLICAS; j++) begin
            if (GW'(j) < r_got && r_chosen[j] == head_srv) begin
                seen = 1'b1;
            end
        end
    end

    // A new head server joins the list when it lies on the walk from the start slot and the list is short.
    always_comb begin
        take = 1'b0;
        if (r_got < r_want && !seen) begin
            if (r_state == S_LK_A) begin
                take = r_found || ge_q;
            end else if (r_state == S_LK_B) begin
                take = !r_found || (CW'(r_pos) > r_k);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_cmd'(i_cmd) == CMD_INSERT && r_count != DEPTH_C) begin
                        n_state = (r_count == '0) ? S_INS_PUT : S_INS_SCAN;
                    end else if (t_cmd'(i_cmd) == CMD_LOOKUP && r_count != '0) begin
                        n_state = S_LK_A;
                    end
                end
            end
            S_INS_SCAN: if (pass_end) n_state = S_INS_PUT;
            S_INS_PUT:  n_state = S_IDLE;
            S_LK_A:     if (pass_end) n_state = S_LK_B;
            S_LK_B: begin
                if (pass_end) begin
                    n_state = ((r_got + GW'(take)) < r_want) ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT:     if (r_e + GW'(1) == r_got) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath, chain control and result outputs.
    always_comb begin
        n_count  = r_count;
        n_k      = r_k;
        n_pos    = r_pos;
        n_found  = r_found;
        n_q      = r_q;
        n_sid    = r_sid;
        n_got    = r_got;
        n_want   = r_want;
        n_e      = r_e;
        n_ovalid = 1'b0;
        n_opos   = '0;
        n_osrv   = '0;
        n_olast  = 1'b1;
        n_ostat  = ST_OK;
        ctl.mode = CM_HOLD;
        ctl.pt   = r_q;
        ctl.srv  = r_sid;
        case (r_state)
            S_IDLE: begin
                n_k     = '0;
                n_found = 1'b0;
                n_got   = '0;
                n_e     = '0;
                n_want  = want_c;
                n_q     = i_point;
                n_sid   = i_server_id;
                n_pos   = AW'(r_count);
                if (accept) begin
                    case (t_cmd'(i_cmd))
                        CMD_CLEAR: begin
                            n_count  = '0;
                            n_ovalid = 1'b1;
                        end
                        CMD_INSERT: begin
                            if (r_count == DEPTH_C) begin
                                n_ovalid = 1'b1;
                                n_osrv   = i_server_id;
                                n_ostat  = ST_FULL;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (r_count == '0) begin
                                n_ovalid = 1'b1;
                                n_ostat  = ST_EMPTY;
                            end
                        end
                        default: n_ovalid = 1'b0;
                    endcase
                end
            end
            S_INS_SCAN: begin
                ctl.mode = CM_ROT;
                n_k      = r_k + CW'(1);
                if (!r_found && head_pt > r_q) begin
                    n_found = 1'b1;
                    n_pos   = AW'(r_k);
                end
            end
            S_INS_PUT: begin
                ctl.mode = CM_INS;
                n_count  = r_count + CW'(1);
                n_ovalid = 1'b1;
                n_opos   = POS_W'(r_pos);
                n_osrv   = r_sid;
            end
            S_LK_A: begin
                ctl.mode = CM_ROT;
                n_k      = pass_end ? '0 : r_k + CW'(1);
                if (!r_found && ge_q) begin
                    n_found = 1'b1;
                    n_pos   = AW'(r_k);
                end
                if (take) n_got = r_got + GW'(1);
            end
            S_LK_B: begin
                ctl.mode = CM_ROT;
                n_k      = r_k + CW'(1);
                if (take) n_got = r_got + GW'(1);
                if (pass_end && (r_got + GW'(take)) < r_want) begin
                    n_ovalid = 1'b1;
                    n_ostat  = ST_FEW;
                end
            end
            S_EMIT: begin
                n_e      = r_e + GW'(1);
                n_ovalid = 1'b1;
                n_opos   = POS_W'(r_slot[r_e[IW-1:0]]);
                n_osrv   = r_chosen[r_e[IW-1:0]];
                n_olast  = (r_e + GW'(1) == r_got);
            end
            default: n_ovalid = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_q     <= n_q;
        r_sid   <= n_sid;
        r_got   <= n_got;
        r_want  <= n_want;
        r_e     <= n_e;
        r_opos  <= n_opos;
        r_osrv  <= n_osrv;
        r_olast <= n_olast;
        r_ostat <= n_ostat;
        if (take) begin
            r_chosen[r_got[IW-1:0]] <= head_srv;
            r_slot[r_got[IW-1:0]]   <= AW'(r_k);
        end
    end

    hrrl_chain #(
        .RING_DEPTH (RING_DEPTH),
        .CW         (CW),
        .AW         (AW)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_count    (r_count),
        .i_pos      (r_pos),
        .o_head_pt  (head_pt),
        .o_head_srv (head_srv)
    );

    assign o_busy     = (r_state != S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_position = r_opos;
    assign o_server   = r_osrv;
    assign o_last     = r_olast;
    assign o_status   = r_ostat;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("ring fill exceeds depth");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && t_cmd'(i_cmd) == CMD_CLEAR |=> o_valid && o_last && r_count == '0)
        else $error("clear did not give one result");

    a_list_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_busy ##1 o_valid)
        else $error("replica list broke off");

    a_emit_has_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_got == r_want && r_e < r_got)
        else $error("emitting without a full replica list");
`endif

endmodule
